// File: rtl/tefb_pkg.sv
package tefb_pkg;
  localparam int EVENT_DEPTH = 1024;
  localparam int REF_DEPTH = 16;
  localparam int EA_W = $clog2(EVENT_DEPTH);
  localparam int EC_W = $clog2(EVENT_DEPTH + 1);
  localparam int RA_W = $clog2(REF_DEPTH);
  localparam int RC_W = $clog2(REF_DEPTH + 1);
  localparam int TS_W = 64;
  localparam int KIND_W = 3;
  localparam int CULL_W = 11;
  localparam int CNT_W = 11;

  localparam logic [KIND_W-1:0] KIND_ADD_EVENT = 3'd0;
  localparam logic [KIND_W-1:0] KIND_ADD_REF   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_FRAME     = 3'd2;
  localparam logic [KIND_W-1:0] KIND_CULL      = 3'd3;
  localparam logic [KIND_W-1:0] KIND_QUERY     = 3'd4;
  localparam logic [KIND_W-1:0] KIND_CLEAR     = 3'd5;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [TS_W-1:0]   timestamp;
    logic [CULL_W-1:0] cull_amount;
  } in_item_t;

  typedef struct packed {
    logic              accepted;
    logic              frame_ready;
    logic [CNT_W-1:0]  event_count;
    logic [TS_W-1:0]   frame_ref_time;
  } out_item_t;
endpackage

// File: rtl/tefb_stream_if.sv
interface tefb_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/tefb_cfg_if.sv
interface tefb_cfg_if;
  logic        valid;
  logic        ready;
  logic [63:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/tefb_event_ram.sv
module tefb_event_ram
  import tefb_pkg::*;
(
  input  logic            clk,
  input  logic            we,
  input  logic [EA_W-1:0] waddr,
  input  logic [TS_W-1:0] wdata,
  input  logic [EA_W-1:0] raddr,
  output logic [TS_W-1:0] rdata
);
  logic [TS_W-1:0] mem [EVENT_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: rtl/timestamped_event_frame_buffer.sv
// Event timestamps go into a 1024-entry circular memory, so a cull only moves
// the head pointer and lowers the fill count. Add event, cull, query, clear and
// the unused kinds pass from the idle state straight to the done state, which
// raises the result beat. An add reference other than the current one walks
// the 16-entry sorted list one entry a cycle for duplicates, then, if new and
// with room, for its insert. A frame request reads the oldest event, walks the
// reference list to pick the reference and to count the stale entries, then
// checks the buffered events one at a time until the frame edge; a full buffer
// skips the event scan. One item is in work at a time, and the next beat is
// taken only after the result beat has left the output register.
module timestamped_event_frame_buffer
  import tefb_pkg::*;
(
  input logic clk,
  input logic rst,
  tefb_cfg_if.sink              cfg,
  tefb_stream_if.sink           in_ch,
  tefb_stream_if.source         out_ch
);
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_FRD    = 4'd1;
  localparam logic [3:0] S_FFIRST = 4'd2;
  localparam logic [3:0] S_FREF   = 4'd3;
  localparam logic [3:0] S_FDROP  = 4'd4;
  localparam logic [3:0] S_FSCAN  = 4'd5;
  localparam logic [3:0] S_FCHK   = 4'd6;
  localparam logic [3:0] S_RDUP   = 4'd7;
  localparam logic [3:0] S_RINS   = 4'd8;
  localparam logic [3:0] S_DONE   = 4'd9;

  logic [3:0]      state;
  logic [TS_W-1:0] max_off;
  logic [EA_W-1:0] head;
  logic [EC_W-1:0] fill;
  logic [TS_W-1:0] cur_ref;
  logic [TS_W-1:0] refs [REF_DEPTH];
  logic [RC_W-1:0] rfill;
  in_item_t        item;
  out_item_t       res;
  out_item_t       idle_res;
  logic            res_valid;
  logic [TS_W-1:0] first;
  logic [RC_W-1:0] ri;
  logic [EC_W-1:0] k;
  logic [RC_W-1:0] rdrop;

  logic            ram_we;
  logic [EA_W-1:0] ram_waddr;
  logic [EA_W-1:0] ram_raddr;
  logic [TS_W-1:0] ram_rdata;

  tefb_event_ram u_ram (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(in_ch.data.timestamp),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  assign cfg.ready = 1'b1;
  assign in_ch.ready = (state == S_IDLE) && !res_valid;
  assign out_ch.valid = res_valid;
  assign out_ch.data = res;

  logic take;
  assign take = in_ch.valid && in_ch.ready;
  assign ram_we = take && (in_ch.data.kind == KIND_ADD_EVENT) && (fill < EC_W'(EVENT_DEPTH));
  assign ram_waddr = head + fill[EA_W-1:0];
  assign ram_raddr = (state == S_FSCAN || state == S_FCHK) ? head + k[EA_W-1:0] : head;

  logic [TS_W-1:0] limit;
  assign limit = cur_ref + max_off;
  logic [EC_W-1:0] camt;
  assign camt = (EC_W'(in_ch.data.cull_amount) > fill) ? fill : EC_W'(in_ch.data.cull_amount);

  // Result as decided in the idle state; the later states of a reference add or a frame may still set its fields.
  always_comb begin
    idle_res = '0;
    case (in_ch.data.kind)
      KIND_ADD_EVENT: idle_res.accepted = (fill < EC_W'(EVENT_DEPTH));
      KIND_ADD_REF: idle_res.accepted = (in_ch.data.timestamp == cur_ref);
      KIND_QUERY: begin
        if (fill != '0) begin
          idle_res.frame_ready = 1'b1;
          idle_res.event_count = CNT_W'(fill);
          idle_res.frame_ref_time = cur_ref;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      max_off <= '0;
      head <= '0;
      fill <= '0;
      cur_ref <= '0;
      rfill <= '0;
      res_valid <= 1'b0;
    end else begin
      if (cfg.valid) begin
        max_off <= cfg.data;
      end
      if (out_ch.valid && out_ch.ready) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (take) begin
            item <= in_ch.data;
            res <= idle_res;
            case (in_ch.data.kind)
              KIND_ADD_EVENT: begin
                if (fill < EC_W'(EVENT_DEPTH)) begin
                  fill <= fill + 1'b1;
                end
                state <= S_DONE;
              end
              KIND_ADD_REF: begin
                if (in_ch.data.timestamp == cur_ref) begin
                  state <= S_DONE;
                end else begin
                  ri <= '0;
                  state <= S_RDUP;
                end
              end
              KIND_FRAME: begin
                state <= (fill != '0) ? S_FRD : S_DONE;
              end
              KIND_CULL: begin
                head <= head + camt[EA_W-1:0];
                fill <= fill - camt;
                state <= S_DONE;
              end
              KIND_CLEAR: begin
                fill <= '0;
                state <= S_DONE;
              end
              default: state <= S_DONE;
            endcase
          end
        end
        S_RDUP: begin
          if (ri == rfill) begin
            if (rfill >= RC_W'(REF_DEPTH)) begin
              state <= S_DONE;
            end else begin
              ri <= rfill;
              state <= S_RINS;
            end
          end else if (refs[ri[RA_W-1:0]] == item.timestamp) begin
            res.accepted <= 1'b1;
            state <= S_DONE;
          end else begin
            ri <= ri + 1'b1;
          end
        end
        S_RINS: begin
          // Shift larger entries up one place, from the top down.
          if (ri != '0 && refs[ri[RA_W-1:0] - 1'b1] >= item.timestamp) begin
            refs[ri[RA_W-1:0]] <= refs[ri[RA_W-1:0] - 1'b1];
            ri <= ri - 1'b1;
          end else begin
            refs[ri[RA_W-1:0]] <= item.timestamp;
            rfill <= rfill + 1'b1;
            res.accepted <= 1'b1;
            state <= S_DONE;
          end
        end
        S_FRD: state <= S_FFIRST;
        S_FFIRST: begin
          first <= ram_rdata;
          if (limit < ram_rdata) begin
            cur_ref <= ram_rdata;
          end
          ri <= rfill;
          state <= S_FREF;
        end
        S_FREF: begin
          if (ri == '0) begin
            rdrop <= '0;
            state <= S_FDROP;
          end else if (refs[ri[RA_W-1:0] - 1'b1] <= first &&
                       refs[ri[RA_W-1:0] - 1'b1] + max_off > first) begin
            cur_ref <= refs[ri[RA_W-1:0] - 1'b1];
            rdrop <= ri;
            state <= S_FDROP;
          end else begin
            ri <= ri - 1'b1;
          end
        end
        S_FDROP: begin
          // Count a further leading run below first, then compact in one step.
          if (rdrop < rfill && refs[rdrop[RA_W-1:0]] < first) begin
            rdrop <= rdrop + 1'b1;
          end else begin
            for (int j = 0; j < REF_DEPTH; j++) begin
              if (RC_W'(j) + rdrop < RC_W'(REF_DEPTH)) begin
                refs[j] <= refs[RA_W'(j) + rdrop[RA_W-1:0]];
              end
            end
            rfill <= rfill - rdrop;
            if (fill >= EC_W'(EVENT_DEPTH)) begin
              res.frame_ready <= 1'b1;
              res.event_count <= CNT_W'(fill);
              res.frame_ref_time <= cur_ref;
              state <= S_DONE;
            end else begin
              k <= '0;
              state <= S_FSCAN;
            end
          end
        end
        S_FSCAN: state <= S_FCHK;
        S_FCHK: begin
          if ((rfill == '0) ? (ram_rdata > limit) : (ram_rdata >= refs[0])) begin
            res.frame_ready <= 1'b1;
            res.event_count <= CNT_W'(k);
            res.frame_ref_time <= cur_ref;
            state <= S_DONE;
          end else if (k + 1'b1 == fill) begin
            state <= S_DONE;
          end else begin
            k <= k + 1'b1;
            state <= S_FSCAN;
          end
        end
        S_DONE: begin
          res_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// File: dv/timestamped_event_frame_buffer_checker.sv
`timescale 1ns / 100ps

module timestamped_event_frame_buffer_checker
  import tefb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  in_item_t    in_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  out_item_t   out_data,
  output int          fail_count,
  output int          outstanding
);

  bit [TS_W-1:0] span;
  bit [TS_W-1:0] ref_now;
  bit [TS_W-1:0] stamps[$];
  bit [TS_W-1:0] refs[$];
  out_item_t     frames_due[$];

  task automatic report(string field, logic [63:0] got, logic [63:0] want);
    $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, field, got, want);
    fail_count++;
  endtask

  function automatic out_item_t frame_for(in_item_t it);
    out_item_t     res;
    bit [TS_W-1:0] first;
    bit [TS_W-1:0] edge_t;
    bit            hit;
    int            pos;
    int            n;
    res = '0;
    case (it.kind)
      KIND_ADD_EVENT: begin
        if (stamps.size() < EVENT_DEPTH) begin
          stamps.insert(stamps.size(), it.timestamp);
          res.accepted = 1'b1;
        end
      end
      KIND_ADD_REF: begin
        hit = (it.timestamp == ref_now);
        foreach (refs[i]) if (refs[i] == it.timestamp) hit = 1'b1;
        if (hit) begin
          res.accepted = 1'b1;
        end else if (refs.size() < REF_DEPTH) begin
          pos = 0;
          while (pos < refs.size() && refs[pos] < it.timestamp) pos++;
          refs.insert(pos, it.timestamp);
          res.accepted = 1'b1;
        end
      end
      KIND_FRAME: begin
        if (stamps.size() != 0) begin
          first = stamps[0];
          if (ref_now + span < first) ref_now = first;
          // Newest reference that still covers the oldest event wins.
          for (int i = refs.size(); i > 0; i--) begin
            if (refs[i-1] <= first && refs[i-1] + span > first) begin
              ref_now = refs[i-1];
              repeat (i) void'(refs.pop_front());
              break;
            end
          end
          while (refs.size() > 0 && refs[0] < first) void'(refs.pop_front());
          if (stamps.size() >= EVENT_DEPTH) begin
            res.frame_ready = 1'b1;
            res.event_count = CNT_W'(stamps.size());
            res.frame_ref_time = ref_now;
          end else begin
            edge_t = ref_now + span;
            for (n = 0; n < stamps.size(); n++) begin
              if (refs.size() == 0 ? (stamps[n] > edge_t) : (stamps[n] >= refs[0])) begin
                res.frame_ready = 1'b1;
                res.event_count = CNT_W'(n);
                res.frame_ref_time = ref_now;
                break;
              end
            end
          end
        end
      end
      KIND_CULL: begin
        n = (it.cull_amount > stamps.size()) ? stamps.size() : it.cull_amount;
        repeat (n) void'(stamps.pop_front());
      end
      KIND_QUERY: begin
        if (stamps.size() != 0) begin
          res.frame_ready = 1'b1;
          res.event_count = CNT_W'(stamps.size());
          res.frame_ref_time = ref_now;
        end
      end
      KIND_CLEAR: stamps.delete();
      default: ;
    endcase
    return res;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      span <= '0;
      ref_now = '0;
      fail_count = 0;
      stamps.delete();
      refs.delete();
      frames_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) span <= cfg_data;
      if (out_valid && out_ready) begin
        if (frames_due.size() == 0) begin
          $display("%0t: result beat with nothing expected", $realtime);
          fail_count++;
        end else begin
          want = frames_due.pop_front();
          if (out_data.accepted !== want.accepted)
            report("accepted", 64'(out_data.accepted), 64'(want.accepted));
          if (out_data.frame_ready !== want.frame_ready)
            report("frame_ready", 64'(out_data.frame_ready), 64'(want.frame_ready));
          if (out_data.event_count !== want.event_count)
            report("event_count", 64'(out_data.event_count), 64'(want.event_count));
          if (out_data.frame_ref_time !== want.frame_ref_time)
            report("frame_ref_time", out_data.frame_ref_time, want.frame_ref_time);
        end
      end
      if (in_valid && in_ready) frames_due.insert(frames_due.size(), frame_for(in_data));
    end
    outstanding = frames_due.size();
  end

endmodule

// File: dv/timestamped_event_frame_buffer_tb.sv
`timescale 1ns / 100ps

module timestamped_event_frame_buffer_tb;
  import tefb_pkg::*;

  logic clk;
  logic rst;
  logic hold;
  int   src_idle;
  int   snk_idle;
  int   fail_count;
  int   outstanding;
  bit [TS_W-1:0] now_ts;

  tefb_cfg_if                    cfg_if();
  tefb_stream_if #(.T(in_item_t))  in_if();
  tefb_stream_if #(.T(out_item_t)) out_if();

  timestamped_event_frame_buffer uut (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_if),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  timestamped_event_frame_buffer_checker chk (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_if.valid),
    .cfg_ready   (cfg_if.ready),
    .cfg_data    (cfg_if.data),
    .in_valid    (in_if.valid),
    .in_ready    (in_if.ready),
    .in_data     (in_if.data),
    .out_valid   (out_if.valid),
    .out_ready   (out_if.ready),
    .out_data    (out_if.data),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  initial begin
    #1_000_000_000;
    $display("Regression FAIL");
    $finish;
  end

  always @(posedge clk) begin
    out_if.ready <= !hold && ($urandom_range(99) >= snk_idle);
  end

  task automatic send(logic [KIND_W-1:0] kind, logic [63:0] ts, logic [CULL_W-1:0] amount);
    if ($urandom_range(99) < src_idle) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.data <= '{kind: kind, timestamp: ts, cull_amount: amount};
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_span(logic [63:0] value);
    drain();
    cfg_if.valid <= 1'b1;
    cfg_if.data <= value;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic hold_off(int cycles);
    hold <= 1'b1;
    repeat (cycles) @(posedge clk);
    hold <= 1'b0;
  endtask

  // Mostly a well-formed stream: rising event times near a base, references
  // close to them, frames, and culls sized to keep the buffer shallow.
  task automatic random_item();
    int pick;
    pick = $urandom_range(99);
    if (pick < 50) begin
      now_ts += $urandom_range(0, 20);
      send(KIND_ADD_EVENT, now_ts, 0);
    end else if (pick < 62) begin
      send(KIND_ADD_REF, now_ts - $urandom_range(0, 40) + $urandom_range(0, 30), 0);
    end else if (pick < 77) begin
      send(KIND_FRAME, {$urandom, $urandom}, CULL_W'($urandom_range(0, 1024)));
    end else if (pick < 88) begin
      send(KIND_CULL, 0, CULL_W'(($urandom_range(9) == 0) ? $urandom_range(0, 1024)
                                                           : $urandom_range(0, 16)));
    end else if (pick < 93) begin
      send(KIND_QUERY, 0, 0);
    end else if (pick < 96) begin
      send(KIND_CLEAR, 0, 0);
    end else if (pick < 98) begin
      send(KIND_W'(6 + $urandom_range(0, 1)), {$urandom, $urandom},
           CULL_W'($urandom_range(0, 1024)));
    end else begin
      send(KIND_ADD_EVENT, {$urandom, $urandom}, 0);
    end
  endtask

  initial begin
    rst = 1'b1;
    hold = 1'b0;
    src_idle = 0;
    snk_idle = 0;
    in_if.valid = 1'b0;
    in_if.data = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    write_span(64'd10);
    send(KIND_QUERY, 0, 0);
    send(KIND_FRAME, 0, 0);
    send(KIND_ADD_EVENT, 64'd0, 0);
    send(KIND_ADD_EVENT, '1, 0);
    send(KIND_ADD_REF, '1, 0);
    send(KIND_ADD_REF, 64'd0, 0);
    send(KIND_FRAME, 0, 0);
    send(KIND_QUERY, 0, 0);
    send(KIND_CULL, 0, 11'd1024);
    send(KIND_ADD_EVENT, 64'd100, 0);
    send(KIND_ADD_EVENT, 64'd105, 0);
    send(KIND_ADD_EVENT, 64'd120, 0);
    send(KIND_ADD_REF, 64'd110, 0);
    send(KIND_ADD_REF, 64'd110, 0);
    send(KIND_FRAME, 0, 0);
    send(KIND_CULL, 0, 11'd1);
    send(KIND_FRAME, 0, 0);
    send(3'd6, '1, '1);
    send(3'd7, '1, '1);
    send(KIND_CLEAR, 0, 0);
    send(KIND_QUERY, 0, 0);

    // Overfill the reference list.
    for (int i = 0; i < REF_DEPTH + 2; i++) send(KIND_ADD_REF, 64'd1000 + 7 * i, 0);

    // Receiver stalls first, then the sender overfills the event buffer.
    fork
      hold_off(3000);
      for (int i = 0; i < EVENT_DEPTH + 6; i++) send(KIND_ADD_EVENT, 64'd990 + i, 0);
    join
    send(KIND_FRAME, 0, 0);
    send(KIND_QUERY, 0, 0);
    send(KIND_CULL, 0, 11'd1024);
    send(KIND_QUERY, 0, 0);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: write_span(64'($urandom_range(0, 40)));
        1: write_span('1);
        2: write_span({$urandom, $urandom});
        default: write_span(64'd0);
      endcase
      send(KIND_CLEAR, 0, 0);
      now_ts = {$urandom, $urandom};
      src_idle = (phase == 0) ? 34 : (phase == 1) ? 87 : 0;
      snk_idle = (phase == 0) ? 87 : (phase == 1) ? 34 : 0;
      repeat (100) random_item();
    end

    drain();
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: timestamped_event_frame_buffer.f
rtl/tefb_pkg.sv
rtl/tefb_stream_if.sv
rtl/tefb_cfg_if.sv
rtl/tefb_event_ram.sv
rtl/timestamped_event_frame_buffer.sv
dv/timestamped_event_frame_buffer_checker.sv
dv/timestamped_event_frame_buffer_tb.sv
